// File: rtl/mbd_pkg.sv
package mbd_pkg;

	localparam int PIX_W         = 32;
	localparam int DIM_W         = 13;
	localparam int ROW_W         = 12;
	localparam int STORE_W       = 36;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int DIM_RESET     = 4096;
	localparam int HEIGHT_LIMIT  = 4096;

	typedef enum logic [1:0] {
		FMT_RGBA8 = 2'd0,
		FMT_R8    = 2'd1,
		FMT_R16   = 2'd2
	} fmt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORMAT = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	// horizontal pair sum in line store layout
	function automatic logic [STORE_W-1:0] pair_add(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b,
		input fmt_t             mode
	);
		logic [STORE_W-1:0] s;
		s = '0;
		unique case (mode)
			FMT_R8:  s[8:0]  = {1'b0, a[7:0]} + {1'b0, b[7:0]};
			FMT_R16: s[16:0] = {1'b0, a[15:0]} + {1'b0, b[15:0]};
			default: begin
				for (int k = 0; k < 4; k++) begin
					s[9*k +: 9] = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
				end
			end
		endcase
		return s;
	endfunction

	// sum of two pair sums divided by four, per channel
	function automatic logic [PIX_W-1:0] quad_avg(
		input logic [STORE_W-1:0] upper,
		input logic [STORE_W-1:0] lower,
		input fmt_t               mode
	);
		logic [PIX_W-1:0] r;
		logic [9:0]       c;
		logic [17:0]      w16;
		r   = '0;
		c   = '0;
		w16 = '0;
		unique case (mode)
			FMT_R8: begin
				c      = {1'b0, upper[8:0]} + {1'b0, lower[8:0]};
				r[7:0] = c[9:2];
			end
			FMT_R16: begin
				w16     = {1'b0, upper[16:0]} + {1'b0, lower[16:0]};
				r[15:0] = w16[17:2];
			end
			default: begin
				for (int k = 0; k < 4; k++) begin
					r[8*k +: 8] = 8'((({1'b0, upper[9*k +: 9]} + {1'b0, lower[9*k +: 9]})
						>> 2));
				end
			end
		endcase
		return r;
	endfunction

endpackage

// File: rtl/mbd_pix_if.sv
interface mbd_pix_if;
	logic                      valid;
	logic                      ready;
	logic [mbd_pkg::PIX_W-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink   (input valid, input pixel_value, output ready);
endinterface

// File: rtl/mbd_avg_if.sv
interface mbd_avg_if;
	logic                      valid;
	logic                      ready;
	logic [mbd_pkg::PIX_W-1:0] avg_pixel;
	logic                      frame_end;

	modport source (output valid, output avg_pixel, output frame_end, input ready);
	modport sink   (input valid, input avg_pixel, input frame_end, output ready);
endinterface

// File: rtl/mbd_cfg_if.sv
interface mbd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mbd_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [mbd_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: rtl/mbd_ram.sv
module mbd_ram #(
	parameter int WIDTH = mbd_pkg::STORE_W,
	parameter int DEPTH = mbd_pkg::MAX_WIDTH_DEF / 2,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: rtl/mipmap_box_downsample_unit.sv
// a result passes stage 1 and the output register after the item ending its 2x2 block
// throughput: one source pixel per cycle while stage 1 is not stalled by the output;
// line store: one write per pair on even rows, one read per pair on odd rows
// reset: counters and held pixel cleared, format RGBA8, width and height at maximum;
// the line store is not cleared, odd rows only read what the row above wrote
module mipmap_box_downsample_unit #(
	parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mbd_pix_if.sink    pix,
	mbd_avg_if.source  avg,
	mbd_cfg_if.sink    cfg
);
	import mbd_pkg::*;

	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int W_RST = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
	localparam int W_END = (W_RST / 2) * 2 - 1;
	localparam int H_END = (HEIGHT_LIMIT / 2) * 2 - 1;

	// configuration, kept in decoded form
	fmt_t             fmt_q;
	logic [XW-1:0]    col_last_q;
	logic [XW-1:0]    col_end_q;
	logic [ROW_W-1:0] row_last_q;
	logic [ROW_W-1:0] row_end_q;

	logic [XW-1:0]    x_q;
	logic [ROW_W-1:0] y_q;
	logic [PIX_W-1:0] held_q;

	logic             cfg_we;
	logic             restart;
	fmt_t             fmt_d;
	logic [WW-1:0]    w_clamp;
	logic [DIM_W-1:0] h_clamp;

	logic               accept;
	logic               wr_en;
	logic               rd_en;
	logic [AW-1:0]      addr;
	logic [STORE_W-1:0] pair_d;
	logic [STORE_W-1:0] rdata;
	logic               end_d;

	logic               valid_s1;
	logic [STORE_W-1:0] pair_s1;
	logic               end_s1;
	logic               s1_adv;

	logic               avg_valid_q;
	logic [PIX_W-1:0]   avg_q;
	logic               avg_end_q;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	always_comb begin
		unique case (cfg.wdata[1:0])
			FMT_R8:  fmt_d = FMT_R8;
			FMT_R16: fmt_d = FMT_R16;
			default: fmt_d = FMT_RGBA8;
		endcase

		if (cfg.wdata < DIM_W'(2)) begin
			w_clamp = WW'(2);
		end else if (32'(cfg.wdata) > 32'(MAX_WIDTH)) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = WW'(cfg.wdata);
		end

		if (cfg.wdata < DIM_W'(2)) begin
			h_clamp = DIM_W'(2);
		end else if (cfg.wdata > DIM_W'(HEIGHT_LIMIT)) begin
			h_clamp = DIM_W'(HEIGHT_LIMIT);
		end else begin
			h_clamp = cfg.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= FMT_RGBA8;
			col_last_q <= XW'(W_RST - 1);
			col_end_q  <= XW'(W_END);
			row_last_q <= ROW_W'(HEIGHT_LIMIT - 1);
			row_end_q  <= ROW_W'(H_END);
		end else if (cfg_we) begin
			unique case (cfg.reg_index)
				REG_FORMAT: fmt_q <= fmt_d;
				REG_WIDTH: begin
					col_last_q <= XW'(w_clamp - WW'(1));
					col_end_q  <= XW'({w_clamp[WW-1:1], 1'b0} - WW'(1));
				end
				REG_HEIGHT: begin
					row_last_q <= ROW_W'(h_clamp - DIM_W'(1));
					row_end_q  <= ROW_W'({h_clamp[DIM_W-1:1], 1'b0} - DIM_W'(1));
				end
				default: ;
			endcase
		end
	end

	// any write inside the register list restarts the frame
	always_comb begin
		unique case (cfg.reg_index)
			REG_FORMAT, REG_WIDTH, REG_HEIGHT: restart = cfg_we;
			default:                           restart = 1'b0;
		endcase
	end

	// front end: pair sum against the held left pixel, store write or read
	assign s1_adv    = valid_s1 && (!avg_valid_q || avg.ready);
	assign pix.ready = !valid_s1 || s1_adv;
	assign accept    = pix.valid && pix.ready;

	assign pair_d = pair_add(held_q, pix.pixel_value, fmt_q);
	assign wr_en  = accept && x_q[0] && !y_q[0];
	assign rd_en  = accept && x_q[0] && y_q[0];
	assign addr   = AW'(x_q >> 1);
	assign end_d  = (y_q == row_end_q) && (x_q == col_end_q);

	mbd_ram #(
		.WIDTH (STORE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr),
		.wdata (pair_d),
		.re    (rd_en),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			held_q <= '0;
		end else begin
			if (accept && !x_q[0]) begin
				held_q <= pix.pixel_value;
			end
			if (restart) begin
				x_q <= '0;
				y_q <= '0;
			end else if (accept) begin
				if (x_q == col_last_q) begin
					x_q <= '0;
					y_q <= (y_q == row_last_q) ? '0 : y_q + ROW_W'(1);
				end else begin
					x_q <= x_q + XW'(1);
				end
			end
		end
	end

	// stage 1: lower pair sum waits for the stored upper pair sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= rd_en;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pair_s1 <= pair_d;
			end_s1  <= end_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_valid_q <= 1'b0;
		end else if (s1_adv) begin
			avg_valid_q <= 1'b1;
		end else if (avg.ready) begin
			avg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			avg_q     <= quad_avg(rdata, pair_s1, fmt_q);
			avg_end_q <= end_s1;
		end
	end

	assign avg.valid     = avg_valid_q;
	assign avg.avg_pixel = avg_q;
	assign avg.frame_end = avg_end_q;

	a_odd_pair_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && x_q[0] && y_q[0]) |=> valid_s1)
		else $error("right pixel of an odd row did not reach stage 1");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(x_q <= col_last_q) && (y_q <= row_last_q))
		else $error("position counters beyond image size");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && x_q == col_last_q && y_q == row_last_q) |=> (x_q == '0 && y_q == '0))
		else $error("counters did not wrap at frame end");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(pair_s1) && $stable(rdata)))
		else $error("stage 1 lost its item while stalled");

	a_even_row_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !y_q[0]) |=> !valid_s1)
		else $error("even row produced a result");
endmodule

// File: tb/sv/mipmap_box_downsample_unit_test.sv
module mipmap_box_downsample_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mbd_pkg::*;

	localparam int MAX_W         = MAX_WIDTH_DEF;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int CLAMP_ITEMS   = 128;
	localparam int SETTLE_CYCLES = 4;
	localparam int PRINT_CAP     = 200;

	// codes outside the package enums
	localparam logic [1:0]           FMT_SPARE  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] avg_pixel;
		logic             frame_end;
	} avg_item_t;

	logic clk;
	logic arst_n;

	mbd_pix_if pix ();
	mbd_avg_if avg ();
	mbd_cfg_if cfg ();

	mipmap_box_downsample_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.avg    (avg),
		.cfg    (cfg)
	);

	// predictor state
	logic [1:0]            fmt_sel;
	logic [CFG_DATA_W-1:0] width_set;
	logic [CFG_DATA_W-1:0] height_set;
	logic [STORE_W-1:0]    line_sums [MAX_W/2];
	logic [PIX_W-1:0]      left_px;
	int                    col_pos;
	int                    row_pos;

	avg_item_t box_avg_due [$];

	bit src_gaps;
	bit snk_gaps;
	int items_sent;
	int results_seen;
	int frames_seen;
	int cfg_writes;
	int error_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int clamp_size(input int v, input int hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return v;
	endfunction

	// per-channel sum of two horizontal neighbors, 9-bit lanes for rgba8
	function automatic logic [STORE_W-1:0] pair_total(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b,
		input logic [1:0]       mode
	);
		logic [STORE_W-1:0] s;
		s = '0;
		case (mode)
			FMT_R8:  s = STORE_W'(a[7:0]) + STORE_W'(b[7:0]);
			FMT_R16: s = STORE_W'(a[15:0]) + STORE_W'(b[15:0]);
			default: begin
				for (int ch = 0; ch < 4; ch++) begin
					s[9*ch +: 9] = 9'(a[8*ch +: 8]) + 9'(b[8*ch +: 8]);
				end
			end
		endcase
		return s;
	endfunction

	function automatic logic [PIX_W-1:0] quad_mean(
		input logic [STORE_W-1:0] up,
		input logic [STORE_W-1:0] lo,
		input logic [1:0]         mode
	);
		logic [PIX_W-1:0] r;
		r = '0;
		case (mode)
			FMT_R8:  r[7:0]  = 8'((10'(up[8:0]) + 10'(lo[8:0])) >> 2);
			FMT_R16: r[15:0] = 16'((18'(up[16:0]) + 18'(lo[16:0])) >> 2);
			default: begin
				for (int ch = 0; ch < 4; ch++) begin
					r[8*ch +: 8] = 8'((10'(up[9*ch +: 9]) + 10'(lo[9*ch +: 9])) >> 2);
				end
			end
		endcase
		return r;
	endfunction

	task automatic box_filter_step(input logic [PIX_W-1:0] px);
		int                 w;
		int                 h;
		logic [STORE_W-1:0] pair;
		avg_item_t          due;
		w = clamp_size(int'(width_set), MAX_W);
		h = clamp_size(int'(height_set), HEIGHT_LIMIT);
		if (col_pos % 2 == 0) begin
			left_px = px;
		end else begin
			pair = pair_total(left_px, px, fmt_sel);
			if (row_pos % 2 == 0) begin
				line_sums[col_pos/2] = pair;
			end else begin
				due.avg_pixel = quad_mean(line_sums[col_pos/2], pair, fmt_sel);
				due.frame_end = (row_pos == (h & ~1) - 1) && (col_pos == (w & ~1) - 1);
				box_avg_due.push_back(due);
			end
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	task automatic flag_mismatch(input string what);
		error_count++;
		if (error_count <= PRINT_CAP) begin
			$display("mismatch at %0t: %s", $time, what);
		end
	endtask

	task automatic check_avg();
		avg_item_t want;
		if (box_avg_due.size() == 0) begin
			flag_mismatch($sformatf("unexpected result %h frame_end %b",
				avg.avg_pixel, avg.frame_end));
			return;
		end
		want = box_avg_due.pop_front();
		results_seen++;
		if (avg.frame_end === 1'b1) frames_seen++;
		if (avg.avg_pixel !== want.avg_pixel) begin
			flag_mismatch($sformatf("result %0d avg_pixel %h, want %h",
				results_seen, avg.avg_pixel, want.avg_pixel));
		end
		if (avg.frame_end !== want.frame_end) begin
			flag_mismatch($sformatf("result %0d frame_end %b, want %b",
				results_seen, avg.frame_end, want.frame_end));
		end
	endtask

	// result side: random stall before each item when snk_gaps is set, then hold ready until it comes
	initial begin
		int hold;
		avg.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = snk_gaps ? $urandom_range(0, 8) : 0;
			if (hold > 0) begin
				avg.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			avg.ready <= 1'b1;
			do @(posedge clk); while (avg.valid !== 1'b1);
			check_avg();
		end
	end

	// valid stays high across back-to-back items when no gap is drawn
	task automatic send_pixel(input logic [PIX_W-1:0] px);
		int gap;
		gap = src_gaps ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid       <= 1'b1;
		pix.pixel_value <= px;
		do @(posedge clk); while (pix.ready !== 1'b1);
		items_sent++;
		box_filter_step(px);
	endtask

	task automatic wait_results_in();
		pix.valid <= 1'b0;
		do @(posedge clk); while (box_avg_due.size() != 0);
	endtask

	task automatic write_reg(
		input logic [CFG_IDX_W-1:0]  idx,
		input logic [CFG_DATA_W-1:0] data
	);
		// even-row items leave no result, so give the pipe time to empty
		wait_results_in();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg.valid     <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wdata     <= data;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		cfg_writes++;
		case (idx)
			REG_FORMAT: fmt_sel    = data[1:0];
			REG_WIDTH:  width_set  = data;
			REG_HEIGHT: height_set = data;
			default:    return;
		endcase
		col_pos = 0;
		row_pos = 0;
	endtask

	// reset width and format, height clamped up from zero; row 0 only fills the store
	task automatic test_default_size();
		src_gaps = 1'b0;
		snk_gaps = 1'b1;
		write_reg(REG_HEIGHT, '0);
		repeat (CLAMP_ITEMS) send_pixel($urandom);
	endtask

	task automatic test_formats();
		logic [1:0] codes [4];
		codes    = '{FMT_RGBA8, FMT_R8, FMT_R16, FMT_SPARE};
		src_gaps = 1'b1;
		snk_gaps = 1'b1;
		write_reg(REG_WIDTH, CFG_DATA_W'(2));
		write_reg(REG_HEIGHT, CFG_DATA_W'(2));
		foreach (codes[i]) begin
			// upper data bits must not matter
			write_reg(REG_FORMAT, {11'($urandom), codes[i]});
			send_pixel('1);
			send_pixel('1);
			send_pixel('1);
			send_pixel('0);
		end
		// odd last column and odd last row
		write_reg(REG_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_HEIGHT, CFG_DATA_W'(3));
		repeat (9) send_pixel($urandom);
	endtask

	task automatic test_register_writes();
		write_reg(REG_FORMAT, CFG_DATA_W'(FMT_R8));
		write_reg(REG_WIDTH, CFG_DATA_W'(2));
		write_reg(REG_HEIGHT, CFG_DATA_W'(4));
		send_pixel($urandom);
		send_pixel($urandom);
		// unknown index leaves the frame position alone
		write_reg(REG_UNUSED, '1);
		send_pixel($urandom);
		send_pixel($urandom);
		send_pixel($urandom);
		// any real write restarts the frame
		write_reg(REG_WIDTH, CFG_DATA_W'(2));
		repeat (4) send_pixel($urandom);
	endtask

	task automatic test_wide_clamp();
		src_gaps = 1'b0;
		write_reg(REG_FORMAT, CFG_DATA_W'(FMT_RGBA8));
		write_reg(REG_WIDTH, '1);
		write_reg(REG_HEIGHT, CFG_DATA_W'(2));
		// a clamped width keeps these items in row 0, so nothing comes out
		repeat (CLAMP_ITEMS) send_pixel($urandom);
	endtask

	// narrow and tall, frame end must not show early
	task automatic test_tall_clamp();
		src_gaps = 1'b0;
		write_reg(REG_WIDTH, '0);
		write_reg(REG_HEIGHT, '1);
		repeat (CLAMP_ITEMS) send_pixel($urandom);
	endtask

	task automatic test_random_frames();
		int          sent;
		int          n;
		int          w;
		int          h;
		int          pick;
		logic [31:0] px;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			src_gaps = ($urandom_range(0, 3) != 0);
			snk_gaps = ($urandom_range(0, 3) != 0);
			if (sent == 0 || $urandom_range(0, 1) == 1) begin
				write_reg(REG_FORMAT, CFG_DATA_W'($urandom));
			end
			if (sent == 0 || $urandom_range(0, 1) == 1) begin
				pick = $urandom_range(0, 9);
				write_reg(REG_WIDTH, CFG_DATA_W'((pick == 0) ? $urandom_range(0, 1) :
					(pick == 1) ? $urandom_range(17, 64) : $urandom_range(2, 16)));
			end
			if (sent == 0 || $urandom_range(0, 1) == 1) begin
				pick = $urandom_range(0, 9);
				write_reg(REG_HEIGHT, CFG_DATA_W'((pick == 0) ? $urandom_range(0, 1) :
					(pick == 1) ? $urandom_range(10, 20) : $urandom_range(2, 9)));
			end
			if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
			w = clamp_size(int'(width_set), MAX_W);
			h = clamp_size(int'(height_set), HEIGHT_LIMIT);
			// mostly whole frames, sometimes a torn one
			n = w * h * $urandom_range(1, 2);
			if ($urandom_range(0, 2) == 0) n += $urandom_range(1, w * h - 1);
			if (n > 500) n = 500;
			for (int i = 0; i < n; i++) begin
				pick = $urandom_range(0, 7);
				px   = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
				send_pixel(px);
				if ($urandom_range(0, 63) == 0) wait_results_in();
			end
			sent += n;
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		pix.valid       = 1'b0;
		pix.pixel_value = '0;
		cfg.valid       = 1'b0;
		cfg.reg_index   = '0;
		cfg.wdata       = '0;
		fmt_sel         = FMT_RGBA8;
		width_set       = CFG_DATA_W'(DIM_RESET);
		height_set      = CFG_DATA_W'(DIM_RESET);
		left_px         = '0;
		col_pos         = 0;
		row_pos         = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_size();
		test_formats();
		test_register_writes();
		test_wide_clamp();
		test_tall_clamp();
		test_random_frames();

		wait_results_in();
		repeat (8) @(posedge clk);
		$display("covered %0d source pixels across %0d register writes: all format codes,",
			items_sent, cfg_writes);
		$display("sizes clamped low to clamped high; %0d averages and %0d level ends checked",
			results_seen, frames_seen);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", error_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
